>>> rtl/pbt_pkg.sv
// Package with the shared types, constants and character decoding of the base tokenizer.
package pbt_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam logic [3:0] SYM_READ_BEGIN = 4'd10;
   localparam logic [3:0] SYM_READ_END   = 4'd11;

   typedef struct packed {
      logic [3:0] symbol;
      logic       symbol_valid;
      logic       end_of_string;
      logic       error;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } entry_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] code;
   } base_type;

   localparam result_type RESULT_ERROR = '{symbol: 4'd0, symbol_valid: 1'b0,
                                           end_of_string: 1'b0, error: 1'b1};

   function automatic base_type base_code(input logic [7:0] c);
      base_type b;
      b.hit = 1'b1;
      case (c)
         8'h41: b.code = 4'd0;
         8'h43: b.code = 4'd1;
         8'h47: b.code = 4'd2;
         8'h54: b.code = 4'd3;
         8'h4E: b.code = 4'd4;
         8'h61: b.code = 4'd5;
         8'h63: b.code = 4'd6;
         8'h67: b.code = 4'd7;
         8'h74: b.code = 4'd8;
         8'h2A: b.code = 4'd9;
         default: begin
            b.hit  = 1'b0;
            b.code = 4'd0;
         end
      endcase
      return b;
   endfunction

endpackage

>>> rtl/pbt_if.sv
// Handshake channel interfaces for characters in and symbols out.
interface pbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface pbt_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] symbol;
   logic       symbol_valid;
   logic       end_of_string;
   logic       error;

   modport source (output valid, output symbol, output symbol_valid,
                   output end_of_string, output error, input ready);
   modport sink (input valid, input symbol, input symbol_valid,
                 input end_of_string, input error, output ready);
endinterface

>>> rtl/pbt_front.sv
// Front part: accepts characters, keeps the parser state and forms the results of each item.
module pbt_front (
   input  logic                clock,
   input  logic                reset,
   pbt_req_if.sink             req_chan,
   input  logic                queue_full,
   output logic                push,
   output pbt_pkg::entry_type  entry
);

   localparam int CW = pbt_pkg::COUNT_WIDTH;

   logic [3:0]    held_symbol_ff, held_symbol_in;
   logic          held_valid_ff, held_valid_in;
   logic          skip_next_ff, skip_next_in;
   logic          reading_ff, reading_in;
   logic [CW-1:0] count_ff, count_in;

   logic              accept;
   logic [7:0]        c;
   logic              is_digit;
   logic              do_parse;
   logic [CW+3:0]     grown;
   logic [CW-1:0]     saturated;
   pbt_pkg::base_type b;
   pbt_pkg::result_type tail;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign c              = req_chan.char_code;
   assign is_digit       = (c >= pbt_pkg::CHAR_ZERO) && (c <= pbt_pkg::CHAR_NINE);
   assign b              = pbt_pkg::base_code(c);
   assign grown = ({4'd0, count_ff} << 3) + ({4'd0, count_ff} << 1)
                  + {{(CW + 0){1'b0}}, c[3:0] - pbt_pkg::CHAR_ZERO[3:0]};
   assign saturated = (grown[CW+3:CW] != 4'd0) ? {CW{1'b1}} : grown[CW-1:0];

   always_comb begin
      held_symbol_in = held_symbol_ff;
      held_valid_in  = held_valid_ff;
      skip_next_in   = skip_next_ff;
      reading_in     = reading_ff;
      count_in       = count_ff;
      do_parse       = 1'b0;
      entry          = '0;
      tail           = '0;

      if (skip_next_ff) begin
         skip_next_in = 1'b0;
      end else if (c == pbt_pkg::CHAR_PLUS || c == pbt_pkg::CHAR_MINUS) begin
         reading_in = 1'b1;
         count_in   = '0;
      end else if (reading_ff) begin
         if (is_digit) begin
            count_in = saturated;
         end else begin
            reading_in = 1'b0;
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end else begin
               do_parse = 1'b1;
            end
         end
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
      end else begin
         do_parse = 1'b1;
      end

      if (do_parse) begin
         if (b.hit || c == pbt_pkg::CHAR_CARET) begin
            if (held_valid_ff) begin
               entry.count        = 2'd1;
               entry.first.symbol = held_symbol_ff;
               entry.first.symbol_valid = 1'b1;
            end
            held_symbol_in = b.hit ? b.code : pbt_pkg::SYM_READ_BEGIN;
            skip_next_in   = !b.hit;
            held_valid_in  = 1'b1;
         end else if (c == pbt_pkg::CHAR_DOLLAR && held_valid_ff) begin
            entry.count              = 2'd1;
            entry.first.symbol       = pbt_pkg::SYM_READ_END;
            entry.first.symbol_valid = 1'b1;
         end else begin
            entry.count = 2'd1;
            entry.first = pbt_pkg::RESULT_ERROR;
         end
      end

      if (req_chan.last_char) begin
         tail.symbol        = held_valid_in ? held_symbol_in : 4'd0;
         tail.symbol_valid  = held_valid_in;
         tail.end_of_string = 1'b1;
         if (entry.count == 2'd0) begin
            entry.first = tail;
         end else begin
            entry.second = tail;
         end
         entry.count    = entry.count + 2'd1;
         held_symbol_in = '0;
         held_valid_in  = 1'b0;
         skip_next_in   = 1'b0;
         reading_in     = 1'b0;
         count_in       = '0;
      end
   end

   assign push = accept && (entry.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_symbol_ff <= '0;
         held_valid_ff  <= 1'b0;
         skip_next_ff   <= 1'b0;
         reading_ff     <= 1'b0;
         count_ff       <= '0;
      end else if (accept) begin
         held_symbol_ff <= held_symbol_in;
         held_valid_ff  <= held_valid_in;
         skip_next_ff   <= skip_next_in;
         reading_ff     <= reading_in;
         count_ff       <= count_in;
      end
   end

endmodule

>>> rtl/pbt_queue.sv
// Short queue of result entries between the front and the back part.
module pbt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pbt_pkg::entry_type push_entry,
   input  logic               pop,
   output pbt_pkg::entry_type pop_entry,
   output logic               full,
   output logic               empty
);

   localparam int AW = pbt_pkg::QUEUE_AW;

   pbt_pkg::entry_type slots_ff [pbt_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]   fill_ff;

   assign full      = (fill_ff == (AW + 1)'(pbt_pkg::QUEUE_DEPTH));
   assign empty     = (fill_ff == '0);
   assign pop_entry = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fill_ff <= fill_ff + (AW + 1)'(push) - (AW + 1)'(pop);
      end
   end

endmodule

>>> rtl/pbt_back.sv
// Back part: takes entries from the queue and sends their results one per cycle while ready.
module pbt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  pbt_pkg::entry_type queue_entry,
   output logic               pop,
   pbt_rsp_if.source          rsp_chan
);

   logic                out_valid_ff;
   pbt_pkg::result_type out_ff;
   logic                spare_valid_ff;
   pbt_pkg::result_type spare_ff;
   logic                can_load;

   assign can_load = !out_valid_ff || rsp_chan.ready;
   assign pop      = can_load && !spare_valid_ff && !queue_empty;

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.symbol        = out_ff.symbol;
   assign rsp_chan.symbol_valid  = out_ff.symbol_valid;
   assign rsp_chan.end_of_string = out_ff.end_of_string;
   assign rsp_chan.error         = out_ff.error;

   always_ff @(posedge clock) begin
      if (can_load) begin
         if (spare_valid_ff) begin
            out_ff <= spare_ff;
         end else begin
            out_ff <= queue_entry.first;
         end
      end
      if (pop) begin
         spare_ff <= queue_entry.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else if (can_load) begin
         if (spare_valid_ff) begin
            out_valid_ff   <= 1'b1;
            spare_valid_ff <= 1'b0;
         end else begin
            out_valid_ff   <= !queue_empty;
            spare_valid_ff <= !queue_empty && (queue_entry.count == 2'd2);
         end
      end
   end

endmodule

>>> rtl/pileup_base_tokenizer_unit.sv
// Top level of the pileup read-base tokenizer.
// The block takes one character of a read-base string per cycle while the queue has room and
// turns it into symbol codes: bases 0 to 9, read begin 10, read end 11, with the latest base or
// read-begin symbol held back until the next one or the last character. A character gives
// zero, one or two results; the result channel sends one result per cycle while it is ready,
// so the block keeps one character per cycle as long as characters give at most one result
// on average. The front part updates the parser state and writes an entry to a four-entry
// queue at the accepting edge; the back part then moves the entry's first result into the
// output register and a second result of the same character into a spare register, from which
// it goes to the output register after the first.
// The queue absorbs stalls on the result side; the character side stalls when it is full.
module pileup_base_tokenizer_unit (
   input  logic      clock,
   input  logic      reset,
   pbt_req_if.sink   req_chan,
   pbt_rsp_if.source rsp_chan
);

   logic               push;
   pbt_pkg::entry_type push_entry;
   logic               pop;
   pbt_pkg::entry_type pop_entry;
   logic               full;
   logic               empty;

   pbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (full),
      .push       (push),
      .entry      (push_entry)
   );

   pbt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (full),
      .empty      (empty)
   );

   pbt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (empty),
      .queue_entry (pop_entry),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule
